[rtl/triangle_face_normal_color_assert.svh]
// Assertion macros for the triangle face normal color block.
`ifndef TRIANGLE_FACE_NORMAL_COLOR_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_COLOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TFNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfnc assertion failed");
`define TFNC_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("tfnc latency assertion failed");
`else
`define TFNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TFNC_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons)
`endif
`endif

[rtl/tfnc_pkg.sv]
package tfnc_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ROOT_WIDTH_DEF  = 2 * COORD_WIDTH_DEF + 2;
  localparam int SIDE_WIDTH_DEF  = 3 * ROOT_WIDTH_DEF + 5;

  localparam int COLOR_WIDTH = 32;
  localparam int CHAN_WIDTH  = 8;
  localparam int QUO_STAGES  = CHAN_WIDTH;

  localparam logic [CHAN_WIDTH-1:0]  ALPHA       = 8'hFF;
  localparam logic [COLOR_WIDTH-1:0] DEGEN_COLOR = 32'hFF80FF80;

endpackage

[rtl/tfnc_root.sv]
module tfnc_root #(
  parameter int ROOT_WIDTH = tfnc_pkg::ROOT_WIDTH_DEF,
  parameter int SIDE_WIDTH = tfnc_pkg::SIDE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [2*ROOT_WIDTH-1:0] in_sum,
  input  logic [SIDE_WIDTH-1:0]   in_side,
  output logic                    out_valid,
  output logic [ROOT_WIDTH-1:0]   out_root,
  output logic [SIDE_WIDTH-1:0]   out_side
);

  localparam int RW = ROOT_WIDTH;
  localparam int SW = 2 * ROOT_WIDTH;

  // one result bit per stage, MSB first; rem holds sum - root^2
  logic                  v_r    [RW];
  logic [SW-1:0]         rem_r  [RW];
  logic [RW-1:0]         root_r [RW];
  logic [SIDE_WIDTH-1:0] side_r [RW];

  genvar i;
  for (i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;
    logic                  v_in;
    logic [SW-1:0]         rem_in;
    logic [SW-1:0]         trial;
    logic [RW-1:0]         root_in;
    logic [SIDE_WIDTH-1:0] side_in;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_sum;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = ({{RW{1'b0}}, root_in} << (B + 1)) | (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[i] <= side_in;
      if (rem_in >= trial) begin
        rem_r[i]  <= rem_in - trial;
        root_r[i] <= root_in | (RW'(1) << B);
      end else begin
        rem_r[i]  <= rem_in;
        root_r[i] <= root_in;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

[rtl/triangle_face_normal_color.sv]
// Channel  | Ports                                   | Handshake
// request  | in_first_x .. in_third_z, in_final_tri. | start && !busy
// result   | out_packed_color, out_degenerate, ...   | out_strobe, one cycle
//
// One request per cycle while busy is low; each result passes through six
// arithmetic stages, one square root stage per root bit, a numerator stage,
// eight divide stages and an output register on its way from its request.
// busy is high only while rst_n is low; reset clears the valid bits only.
// Results cannot be held off, so nothing in the pipeline ever stalls.
`include "triangle_face_normal_color_assert.svh"

module triangle_face_normal_color #(
  parameter int COORD_WIDTH = tfnc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_first_x,
  input  logic signed [COORD_WIDTH-1:0]       in_first_y,
  input  logic signed [COORD_WIDTH-1:0]       in_first_z,
  input  logic signed [COORD_WIDTH-1:0]       in_second_x,
  input  logic signed [COORD_WIDTH-1:0]       in_second_y,
  input  logic signed [COORD_WIDTH-1:0]       in_second_z,
  input  logic signed [COORD_WIDTH-1:0]       in_third_x,
  input  logic signed [COORD_WIDTH-1:0]       in_third_y,
  input  logic signed [COORD_WIDTH-1:0]       in_third_z,
  input  logic                                in_final_triangle,
  output logic                                out_strobe,
  output logic [tfnc_pkg::COLOR_WIDTH-1:0]    out_packed_color,
  output logic                                out_degenerate,
  output logic                                out_final_out
);

  localparam int CW     = COORD_WIDTH;
  localparam int EW     = CW + 1;
  localparam int PW     = 2 * EW;
  localparam int NW     = 2 * EW;
  localparam int HW     = EW;
  localparam int SW     = 2 * NW;
  localparam int RW     = NW;
  localparam int QW     = RW + 9;
  localparam int QS     = tfnc_pkg::QUO_STAGES;
  localparam int CH     = tfnc_pkg::CHAN_WIDTH;
  localparam int SIDE_W = 3 * NW + 5;
  localparam int NEG_LO = 3 * NW;
  localparam int DEG_B  = 3 * NW + 3;
  localparam int FIN_B  = 3 * NW + 4;
  localparam int LAT    = RW + 16;

  assign busy = ~rst_n;

  // stage 1: edges
  logic                 v1_r;
  logic                 fin1_r;
  logic signed [EW-1:0] edg_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    fin1_r   <= in_final_triangle;
    edg_r[0] <= EW'(in_second_x) - EW'(in_first_x);
    edg_r[1] <= EW'(in_second_y) - EW'(in_first_y);
    edg_r[2] <= EW'(in_second_z) - EW'(in_first_z);
    edg_r[3] <= EW'(in_third_x) - EW'(in_first_x);
    edg_r[4] <= EW'(in_third_y) - EW'(in_first_y);
    edg_r[5] <= EW'(in_third_z) - EW'(in_first_z);
  end

  // stage 2: cross product terms
  logic                 v2_r;
  logic                 fin2_r;
  logic signed [PW-1:0] prod_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    fin2_r    <= fin1_r;
    prod_r[0] <= edg_r[1] * edg_r[5];
    prod_r[1] <= edg_r[2] * edg_r[4];
    prod_r[2] <= edg_r[2] * edg_r[3];
    prod_r[3] <= edg_r[0] * edg_r[5];
    prod_r[4] <= edg_r[0] * edg_r[4];
    prod_r[5] <= edg_r[1] * edg_r[3];
  end

  // stage 3: normal as sign and magnitude
  logic              v3_r;
  logic [SIDE_W-1:0] side3_r;
  logic [NW-1:0]     mag_nxt [3];
  logic [2:0]        neg_nxt;

  genvar c;
  for (c = 0; c < 3; c++) begin : g_cross
    logic signed [PW:0] dif;
    logic        [PW:0] absv;
    assign dif        = (PW + 1)'(prod_r[2*c]) - (PW + 1)'(prod_r[2*c+1]);
    assign absv       = dif[PW] ? -dif : dif;
    assign mag_nxt[c] = absv[NW-1:0];
    assign neg_nxt[c] = dif[PW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= {fin2_r, ~|{mag_nxt[2], mag_nxt[1], mag_nxt[0]}, neg_nxt,
                mag_nxt[2], mag_nxt[1], mag_nxt[0]};
  end

  // stage 4: partial squares; stage 5: squares; stage 6: sum
  logic              v4_r, v5_r, v6_r;
  logic [SIDE_W-1:0] side4_r, side5_r, side6_r;
  logic [2*HW-1:0]   hh_r [3];
  logic [2*HW-1:0]   hl_r [3];
  logic [2*HW-1:0]   ll_r [3];
  logic [SW-1:0]     sq_r [3];
  logic [SW-1:0]     sum_r;

  for (c = 0; c < 3; c++) begin : g_square
    logic [HW-1:0] hi, lo;
    assign hi = side3_r[c*NW+HW +: HW];
    assign lo = side3_r[c*NW +: HW];

    always_ff @(posedge clk) begin
      hh_r[c] <= hi * hi;
      hl_r[c] <= hi * lo;
      ll_r[c] <= lo * lo;
      sq_r[c] <= {hh_r[c], {(2 * HW){1'b0}}} + (SW'(hl_r[c]) << (HW + 1))
                 + SW'(ll_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    side4_r <= side3_r;
    side5_r <= side4_r;
    side6_r <= side5_r;
    sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  // length
  logic              root_v;
  logic [RW-1:0]     root_len;
  logic [SIDE_W-1:0] root_side;

  tfnc_root #(
    .ROOT_WIDTH (RW),
    .SIDE_WIDTH (SIDE_W)
  ) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_sum    (sum_r),
    .in_side   (side6_r),
    .out_valid (root_v),
    .out_root  (root_len),
    .out_side  (root_side)
  );

  // numerator 256L +/- 255n, denominator 2L
  logic          ve_r;
  logic [1:0]    meta_r;
  logic [RW:0]   den_r;
  logic [QW-1:0] num_r [3];

  for (c = 0; c < 3; c++) begin : g_num
    logic [QW-1:0] n, l, n255;
    assign n    = QW'(root_side[c*NW +: NW]);
    assign l    = QW'(root_len);
    assign n255 = (n << 8) - n;

    always_ff @(posedge clk) begin
      num_r[c] <= root_side[NEG_LO + c] ? (l << 8) - n255 : (l << 8) + n255;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= root_v;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= {root_side[FIN_B], root_side[DEG_B]};
    den_r  <= {root_len, 1'b0};
  end

  // restoring divide, one quotient bit per stage
  logic          dv_r   [QS];
  logic [1:0]    dmeta_r[QS];
  logic [RW:0]   dden_r [QS];
  logic [QW-1:0] rem_r  [QS][3];
  logic [CH-1:0] quo_r  [QS][3];

  genvar k;
  for (k = 0; k < QS; k++) begin : g_div
    localparam int BIT = QS - 1 - k;
    logic          v_in;
    logic [1:0]    meta_in;
    logic [RW:0]   den_in;
    logic [QW-1:0] rem_in [3];
    logic [CH-1:0] quo_in [3];
    logic [QW-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in    = ve_r;
      assign meta_in = meta_r;
      assign den_in  = den_r;
      for (c = 0; c < 3; c++) begin : g_lane
        assign rem_in[c] = num_r[c];
        assign quo_in[c] = '0;
      end
    end else begin : g_rest
      assign v_in    = dv_r[k-1];
      assign meta_in = dmeta_r[k-1];
      assign den_in  = dden_r[k-1];
      for (c = 0; c < 3; c++) begin : g_lane
        assign rem_in[c] = rem_r[k-1][c];
        assign quo_in[c] = quo_r[k-1][c];
      end
    end

    assign trial = QW'(den_in) << BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dmeta_r[k] <= meta_in;
      dden_r[k]  <= den_in;
    end

    for (c = 0; c < 3; c++) begin : g_step
      always_ff @(posedge clk) begin
        if (rem_in[c] >= trial) begin
          rem_r[k][c] <= rem_in[c] - trial;
          quo_r[k][c] <= quo_in[c] | (CH'(1) << BIT);
        end else begin
          rem_r[k][c] <= rem_in[c];
          quo_r[k][c] <= quo_in[c];
        end
      end
    end
  end

  // output register
  logic                             out_v_r;
  logic [tfnc_pkg::COLOR_WIDTH-1:0] color_r;
  logic                             degen_r;
  logic                             fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_r[QS-1];
    end
  end

  always_ff @(posedge clk) begin
    degen_r <= dmeta_r[QS-1][0];
    fin_r   <= dmeta_r[QS-1][1];
    color_r <= dmeta_r[QS-1][0] ? tfnc_pkg::DEGEN_COLOR
               : {tfnc_pkg::ALPHA, quo_r[QS-1][2], quo_r[QS-1][1], quo_r[QS-1][0]};
  end

  assign out_strobe       = out_v_r;
  assign out_packed_color = color_r;
  assign out_degenerate   = degen_r;
  assign out_final_out    = fin_r;

  `TFNC_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LAT, out_strobe)
  `TFNC_ASSERT_IMP(a_alpha, clk, rst_n, out_strobe, out_packed_color[31:24] == tfnc_pkg::ALPHA)
  `TFNC_ASSERT_IMP(a_degen, clk, rst_n, out_strobe && out_degenerate, out_packed_color == tfnc_pkg::DEGEN_COLOR)

endmodule

[sim/tb_triangle_face_normal_color.sv]
`timescale 1ns / 100ps

module tb_triangle_face_normal_color;

  localparam int CW = tfnc_pkg::COORD_WIDTH_DEF;
  localparam int COLW = tfnc_pkg::COLOR_WIDTH;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam int LATENCY = 2 * CW + 18;

  typedef struct {
    logic signed [CW-1:0] c[9];
    logic                 last;
  } tri_req_t;

  typedef struct {
    logic [COLW-1:0] color;
    logic            degen;
    logic            last;
  } color_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [CW-1:0] in_c[9];
  logic in_final_triangle = 0;
  logic out_strobe;
  logic [COLW-1:0] out_packed_color;
  logic out_degenerate;
  logic out_final_out;

  color_res_t pending_colors[$];
  tri_req_t   dir_tris[$];
  bit         dir_typed[$];
  color_res_t dir_want[$];
  int fails = 0;
  int sender_idle_pct = 0;

  initial for (int i = 0; i < 9; i++) in_c[i] = '0;

  always #6 clk = ~clk;

  triangle_face_normal_color uut (
    .clk, .rst_n, .start, .busy,
    .in_first_x(in_c[0]), .in_first_y(in_c[1]), .in_first_z(in_c[2]),
    .in_second_x(in_c[3]), .in_second_y(in_c[4]), .in_second_z(in_c[5]),
    .in_third_x(in_c[6]), .in_third_y(in_c[7]), .in_third_z(in_c[8]),
    .in_final_triangle, .out_strobe, .out_packed_color, .out_degenerate,
    .out_final_out
  );

  function automatic logic [7:0] encode_chan(longint n, logic [127:0] len);
    logic signed [127:0] num;
    logic signed [127:0] ln;
    logic signed [127:0] nw;
    ln = len;
    nw = 128'(n);
    num = 256 * ln + 255 * nw;
    return 8'(num / (2 * ln));
  endfunction

  function automatic color_res_t face_color(tri_req_t t);
    color_res_t r;
    longint ax, ay, az, bx, by, bz, nx, ny, nz;
    logic signed [127:0] wx, wy, wz;
    logic [127:0] sum, len, cand;
    ax = longint'(t.c[3]) - longint'(t.c[0]);
    ay = longint'(t.c[4]) - longint'(t.c[1]);
    az = longint'(t.c[5]) - longint'(t.c[2]);
    bx = longint'(t.c[6]) - longint'(t.c[0]);
    by = longint'(t.c[7]) - longint'(t.c[1]);
    bz = longint'(t.c[8]) - longint'(t.c[2]);
    nx = ay * bz - az * by;
    ny = az * bx - ax * bz;
    nz = ax * by - ay * bx;
    wx = 128'(nx); wy = 128'(ny); wz = 128'(nz);
    sum = wx * wx + wy * wy + wz * wz;
    r.last = t.last;
    if (sum == 0) begin
      r.color = tfnc_pkg::DEGEN_COLOR;
      r.degen = 1'b1;
    end else begin
      len = 0;
      for (int b = 2 * CW + 1; b >= 0; b--) begin
        cand = len | (128'd1 << b);
        if (cand * cand <= sum) len = cand;
      end
      r.color = {tfnc_pkg::ALPHA, encode_chan(nz, len), encode_chan(ny, len),
                 encode_chan(nx, len)};
      r.degen = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_row(tri_req_t t, bit typed, color_res_t w);
    dir_tris.insert(dir_tris.size(), t);
    dir_typed.insert(dir_typed.size(), typed);
    dir_want.insert(dir_want.size(), w);
  endfunction

  always @(posedge clk) begin
    if (out_strobe) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result color %h", out_packed_color);
        fails++;
      end else begin
        color_res_t e;
        e = pending_colors.pop_front();
        if (out_packed_color !== e.color) begin
          $error("packed_color expected %h actual %h", e.color, out_packed_color);
          fails++;
        end
        if (out_degenerate !== e.degen) begin
          $error("degenerate expected %b actual %b", e.degen, out_degenerate);
          fails++;
        end
        if (out_final_out !== e.last) begin
          $error("final_out expected %b actual %b", e.last, out_final_out);
          fails++;
        end
      end
    end
  end

  task automatic send_tri(tri_req_t t, bit typed, color_res_t want);
    for (int i = 0; i < 9; i++) in_c[i] <= t.c[i];
    in_final_triangle <= t.last;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_colors.insert(pending_colors.size(), typed ? want : face_color(t));
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
  endtask

  function automatic tri_req_t rand_tri();
    tri_req_t t;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 5) t.c[i] = CW'($urandom);
      else t.c[i] = CW'($signed($urandom_range(64)) - 32);
    end
    if (mode == 9) begin
      int k;
      k = $signed($urandom_range(6)) - 3;
      for (int i = 0; i < 3; i++) t.c[6 + i] = CW'(t.c[i] + k * (t.c[3 + i] - t.c[i]));
    end
    t.last = 1'($urandom_range(1));
    return t;
  endfunction

  initial begin
    tri_req_t t;
    color_res_t w;
    int idles[3];
    idles = '{33, 83, 0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all zero: degenerate
    t.c = '{default: '0}; t.last = 1'b0;
    w = '{tfnc_pkg::DEGEN_COLOR, 1'b1, 1'b0};
    add_row(t, 1, w);
    // coincident extremes: degenerate, last set
    t.c = '{CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX}; t.last = 1'b1;
    w = '{tfnc_pkg::DEGEN_COLOR, 1'b1, 1'b1};
    add_row(t, 1, w);
    // +z normal
    t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; t.last = 1'b0;
    w = '{32'hFFFF8080, 1'b0, 1'b0};
    add_row(t, 1, w);
    // -z normal
    t.c = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; t.last = 1'b1;
    w = '{32'hFF008080, 1'b0, 1'b1};
    add_row(t, 1, w);
    // collinear
    t.c = '{1, 2, 3, 2, 4, 6, -5, -10, -15}; t.last = 1'b0;
    w = '{tfnc_pkg::DEGEN_COLOR, 1'b1, 1'b0};
    add_row(t, 1, w);
    // full-range edges
    t.c = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}; t.last = 1'b0;
    add_row(t, 0, w);
    t.c = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN}; t.last = 1'b1;
    add_row(t, 0, w);
    t.c = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN}; t.last = 1'b0;
    add_row(t, 0, w);
    t.c = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX}; t.last = 1'b1;
    add_row(t, 0, w);
    t.c = '{-1, -1, -1, 0, -1, -1, -1, -1, CMAX}; t.last = 1'b0;
    add_row(t, 0, w);
    t.c = '{0, 0, 0, 3, -7, 11, -13, 5, 2}; t.last = 1'b0;
    add_row(t, 0, w);

    sender_idle_pct = 33;
    foreach (dir_tris[i]) send_tri(dir_tris[i], dir_typed[i], dir_want[i]);

    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = idles[p];
      for (int n = 0; n < 200; n++) send_tri(rand_tri(), 0, w);
      if (p == 0) begin
        start <= 1'b0;
        while (pending_colors.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/tfnc_pkg.sv
rtl/tfnc_root.sv
rtl/triangle_face_normal_color.sv
sim/tb_triangle_face_normal_color.sv
